/* hw/rtl/jdce_pkg.sv */
// Shared types and constants for the joint distribution condition engine.
// No dependencies; imported by jdce_div and joint_dist_condition_engine_unit.
package jdce_pkg;

    localparam int FRAC_BITS   = 32;
    localparam int VAL_W       = FRAC_BITS + 1;
    localparam int IDX_FIELD_W = 8;

    localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_READ    = 3'd1,
        ACT_SET     = 3'd2,
        ACT_ASSERT  = 3'd3,
        ACT_NASSERT = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_ALL_REMOVED = 2'd1,
        STATUS_SATURATED   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SET_SRC,
        ST_SET_DST,
        ST_SET_ADD,
        ST_SET_CLR,
        ST_CND_SCAN,
        ST_CND_ACC,
        ST_CND_CHECK,
        ST_NRM_RD,
        ST_NRM_START,
        ST_NRM_WAIT,
        ST_DONE
    } jdce_state_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
        logic             sat;
    } div_rsp_t;

endpackage

/* hw/rtl/jdce_div.sv */
// Serial restoring divider: floor(p * ONE / d), saturated at ONE.
// One quotient bit per cycle. Depends on jdce_pkg.
module jdce_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  jdce_pkg::div_req_t req,
    output jdce_pkg::div_rsp_t rsp
);
    import jdce_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             sat_reg, sat_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W:0]   rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0] dvs_reg, dvs_next;
    logic [VAL_W:0]   rem_shift;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_shift = {rem_reg[VAL_W-1:0], 1'b0};
        if (req.start) begin
            dvs_next = req.divisor;
            sat_next = 1'b0;
            if (req.dividend > req.divisor) begin
                quo_next  = ONE;
                sat_next  = 1'b1;
                done_next = 1'b1;
            end else if (req.dividend == req.divisor) begin
                quo_next  = ONE;
                done_next = 1'b1;
            end else begin
                rem_next  = {1'b0, req.dividend};
                quo_next  = '0;
                cnt_next  = CNT_W'(FRAC_BITS);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next = rem_shift - {1'b0, dvs_reg};
                quo_next = {quo_reg[VAL_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.sat      = sat_reg;

endmodule

/* hw/rtl/joint_dist_condition_engine_unit.sv */
// Joint distribution condition engine: table of 2^PLACES probabilities
// (unsigned, 32 fraction bits) with write, read, set, assert and nassert.
// Depends on jdce_pkg and jdce_div.
//
// After reset the table is cleared by a pass over every entry with s_ready
// low. One item at a time is processed through one table and one
// serial divider. Write stores the entry value and read returns a registered
// table read. Set walks every marking and moves each one not on its target.
// Assert and nassert scan the table and clear the removed markings; when mass
// was removed but not all of it, every entry is renormalized through the
// divider, one entry at a time.
// Results sit in an output register, so a new item is taken while the last
// result still waits for m_ready.
module joint_dist_condition_engine_unit #(
    parameter int PLACES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_action,
    input  logic [jdce_pkg::IDX_FIELD_W-1:0]    s_entry_index,
    input  logic [jdce_pkg::VAL_W-1:0]          s_entry_value,
    input  logic [jdce_pkg::IDX_FIELD_W-1:0]    s_place_mask,
    input  logic                                s_target_bit,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [jdce_pkg::VAL_W-1:0]          m_read_value,
    output logic [jdce_pkg::VAL_W-1:0]          m_removed_mass,
    output logic [1:0]                          m_status
);
    import jdce_pkg::*;

    localparam int DEPTH = 1 << PLACES;

    jdce_state_t       state_reg, state_next;
    logic [PLACES-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    action_t           action_reg, action_next;
    logic [PLACES-1:0] idx_reg, idx_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [PLACES-1:0] mask_reg, mask_next;
    logic [PLACES-1:0] pattern_reg, pattern_next;
    logic [VAL_W-1:0]  src_reg, src_next;
    logic [VAL_W-1:0]  removed_reg, removed_next;
    logic [VAL_W-1:0]  divisor_reg, divisor_next;
    logic [VAL_W-1:0]  read_val_reg, read_val_next;
    logic              sat_reg, sat_next;
    logic              all_removed_reg, all_removed_next;

    logic [VAL_W-1:0]  out_read_reg, out_read_next;
    logic [VAL_W-1:0]  out_removed_reg, out_removed_next;
    status_t           out_status_reg, out_status_next;

    logic [VAL_W-1:0]  mem [DEPTH];
    logic [VAL_W-1:0]  rd_data_reg;
    logic              mem_we, mem_re;
    logic [PLACES-1:0] mem_waddr, mem_raddr;
    logic [VAL_W-1:0]  mem_wdata;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [PLACES-1:0] set_target;
    logic              cnd_remove;
    logic [VAL_W:0]    wide_sum;
    logic              last;

    jdce_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Table with separate write and read ports: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign set_target = (cnt_reg & ~mask_reg) | pattern_reg;
    // assert keeps matching markings, nassert removes them
    assign cnd_remove = (((cnt_reg & mask_reg) == pattern_reg) != (action_reg == ACT_ASSERT));
    assign last       = &cnt_reg;

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg;
        action_next      = action_reg;
        idx_next         = idx_reg;
        value_next       = value_reg;
        mask_next        = mask_reg;
        pattern_next     = pattern_reg;
        src_next         = src_reg;
        removed_next     = removed_reg;
        divisor_next     = divisor_reg;
        read_val_next    = read_val_reg;
        sat_next         = sat_reg;
        all_removed_next = all_removed_reg;
        out_read_next    = out_read_reg;
        out_removed_next = out_removed_reg;
        out_status_next  = out_status_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = cnt_reg;
        mem_raddr        = cnt_reg;
        mem_wdata        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = rd_data_reg;
        div_req.divisor  = divisor_reg;
        wide_sum         = {1'b0, rd_data_reg} + {1'b0, src_reg};
        s_ready          = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (last) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + PLACES'(1);
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next      = action_t'(s_action);
                    idx_next         = PLACES'(s_entry_index);
                    value_next       = s_entry_value;
                    mask_next        = PLACES'(s_place_mask);
                    pattern_next     = s_target_bit ? PLACES'(s_place_mask) : '0;
                    removed_next     = '0;
                    read_val_next    = '0;
                    sat_next         = 1'b0;
                    all_removed_next = 1'b0;
                    cnt_next         = '0;
                    state_next       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (action_reg)
                    ACT_WRITE: begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        if (value_reg > ONE) begin
                            mem_wdata = ONE;
                            sat_next  = 1'b1;
                        end else begin
                            mem_wdata = value_reg;
                        end
                        state_next = ST_DONE;
                    end
                    ACT_READ: begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_reg;
                        state_next = ST_READ_WAIT;
                    end
                    ACT_SET: begin
                        state_next = ST_SET_SRC;
                    end
                    ACT_ASSERT, ACT_NASSERT: begin
                        state_next = ST_CND_SCAN;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ_WAIT: begin
                read_val_next = rd_data_reg;
                state_next    = ST_DONE;
            end
            // markings already on their target stay put
            ST_SET_SRC: begin
                if (set_target == cnt_reg) begin
                    if (last) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next = cnt_reg + PLACES'(1);
                    end
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_SET_DST;
                end
            end
            ST_SET_DST: begin
                src_next   = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = set_target;
                state_next = ST_SET_ADD;
            end
            ST_SET_ADD: begin
                mem_we    = 1'b1;
                mem_waddr = set_target;
                if (wide_sum > {1'b0, ONE}) begin
                    mem_wdata = ONE;
                    sat_next  = 1'b1;
                end else begin
                    mem_wdata = wide_sum[VAL_W-1:0];
                end
                state_next = ST_SET_CLR;
            end
            ST_SET_CLR: begin
                mem_we = 1'b1;
                if (last) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next   = cnt_reg + PLACES'(1);
                    state_next = ST_SET_SRC;
                end
            end
            ST_CND_SCAN: begin
                if (cnd_remove) begin
                    mem_re     = 1'b1;
                    state_next = ST_CND_ACC;
                end else if (last) begin
                    state_next = ST_CND_CHECK;
                end else begin
                    cnt_next = cnt_reg + PLACES'(1);
                end
            end
            ST_CND_ACC: begin
                wide_sum = {1'b0, rd_data_reg} + {1'b0, removed_reg};
                if (wide_sum > {1'b0, ONE}) begin
                    removed_next = ONE;
                end else begin
                    removed_next = wide_sum[VAL_W-1:0];
                end
                mem_we = 1'b1;
                if (last) begin
                    state_next = ST_CND_CHECK;
                end else begin
                    cnt_next   = cnt_reg + PLACES'(1);
                    state_next = ST_CND_SCAN;
                end
            end
            ST_CND_CHECK: begin
                cnt_next = '0;
                if (removed_reg >= ONE) begin
                    all_removed_next = 1'b1;
                    state_next       = ST_DONE;
                end else if (removed_reg != '0) begin
                    divisor_next = ONE - removed_reg;
                    state_next   = ST_NRM_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_NRM_RD: begin
                mem_re     = 1'b1;
                state_next = ST_NRM_START;
            end
            ST_NRM_START: begin
                div_req.start = 1'b1;
                state_next    = ST_NRM_WAIT;
            end
            ST_NRM_WAIT: begin
                if (div_rsp.done) begin
                    mem_we    = 1'b1;
                    mem_wdata = div_rsp.quotient;
                    if (div_rsp.sat) begin
                        sat_next = 1'b1;
                    end
                    if (last) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next   = cnt_reg + PLACES'(1);
                        state_next = ST_NRM_RD;
                    end
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    out_read_next    = read_val_reg;
                    out_removed_next = removed_reg;
                    if (all_removed_reg) begin
                        out_status_next = STATUS_ALL_REMOVED;
                    end else if (sat_reg) begin
                        out_status_next = STATUS_SATURATED;
                    end else begin
                        out_status_next = STATUS_OK;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        action_reg      <= action_next;
        idx_reg         <= idx_next;
        value_reg       <= value_next;
        mask_reg        <= mask_next;
        pattern_reg     <= pattern_next;
        src_reg         <= src_next;
        removed_reg     <= removed_next;
        divisor_reg     <= divisor_next;
        read_val_reg    <= read_val_next;
        sat_reg         <= sat_next;
        all_removed_reg <= all_removed_next;
        out_read_reg    <= out_read_next;
        out_removed_reg <= out_removed_next;
        out_status_reg  <= out_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_read_value   = out_read_reg;
    assign m_removed_mass = out_removed_reg;
    assign m_status       = out_status_reg;

endmodule
